>>> rtl/moving_average_anomaly_detector_core_macros.svh
// Assertion macros for the moving average anomaly detector.
// Expects signals clk and rst_n in the scope of use.
`ifndef MOVING_AVERAGE_ANOMALY_DETECTOR_CORE_MACROS_SVH
`define MOVING_AVERAGE_ANOMALY_DETECTOR_CORE_MACROS_SVH

// same-cycle implication
`define MAD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mad_pkg.sv
// Shared constants and types for the moving average anomaly detector.
// No dependencies.
package mad_pkg;

    localparam int WINDOW_LEN  = 7;
    localparam int MAX_SAMPLES = 1048576;

    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 15;
    localparam int POS_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int WSUM_W   = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int DEV_W    = WSUM_W + 1;
    localparam int THRX_W   = THR_W + $clog2(WINDOW_LEN);
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int TOTAL_W  = SAMPLE_W + $clog2(MAX_SAMPLES) + 1;
    localparam int QUO_W    = TOTAL_W;
    localparam int STEP_W   = $clog2(QUO_W);

    localparam int RECIP_SHIFT = WSUM_W - 1 + $clog2(WINDOW_LEN);
    localparam int PROD_W      = 2 * WSUM_W;
    localparam logic [WSUM_W-1:0] RECIP_MUL =
        WSUM_W'(((longint'(1) << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(640);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] moving_avg;
        logic                       window_full;
        logic                       anomaly;
        logic [CNT_W-1:0]           anomaly_total;
        logic signed [SAMPLE_W-1:0] overall_mean;
        logic                       final_res;
    } out_t;

    typedef struct packed {
        logic              start;
        logic [QUO_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [QUO_W-1:0]  quotient;
    } div_rsp_t;

endpackage

>>> rtl/mad_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on mad_pkg.
module mad_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  mad_pkg::div_req_t req,
    output mad_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic [mad_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [mad_pkg::QUO_W-1:0]     quo_reg, quo_next;
    logic [mad_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [mad_pkg::CNT_W-1:0]     dvs_reg, dvs_next;
    logic [mad_pkg::CNT_W:0]       rem_shift;
    logic [mad_pkg::CNT_W:0]       diff;

    assign rem_shift = {rem_reg, quo_reg[mad_pkg::QUO_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            if (!diff[mad_pkg::CNT_W])
            begin
                rem_next = diff[mad_pkg::CNT_W-1:0];
                quo_next = {quo_reg[mad_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[mad_pkg::CNT_W-1:0];
                quo_next = {quo_reg[mad_pkg::QUO_W-2:0], 1'b0};
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            step_next = mad_pkg::STEP_W'(mad_pkg::QUO_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/moving_average_anomaly_detector_core.sv
// Top level of the moving average anomaly detector: sequencer and datapath.
// Depends on mad_pkg, mad_div and moving_average_anomaly_detector_core_macros.svh.
//
//   channel | direction | handshake          | payload
//   in      | into      | in_valid/in_stall  | in_data   (mad_pkg::in_t)
//   out     | out of    | out_valid/out_stall| out_data  (mad_pkg::out_t)
//   cfg     | into      | cfg_valid/cfg_ready| cfg_data  (anomaly threshold)
//
// An item passes the update, deviation, compare and output steps in turn; the
// next item is accepted once idle again. The window mean comes from a reciprocal
// multiply in the compare step. The last item of a set also passes the mean step,
// which divides the 37-bit total, one quotient bit a cycle, into the data-set mean.
// No clearing pass after reset; cfg_ready is always high.
// A stalled result holds in the output register; the next item waits in the output step.
`include "moving_average_anomaly_detector_core_macros.svh"

module moving_average_anomaly_detector_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  mad_pkg::in_t                in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output mad_pkg::out_t               out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mad_pkg::THR_W-1:0]   cfg_data
);

    typedef enum logic [5:0]
    {
        S_IDLE = 6'b000001,
        S_UPD  = 6'b000010,
        S_DEV  = 6'b000100,
        S_CMP  = 6'b001000,
        S_MEAN = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    localparam logic signed [mad_pkg::DEV_W-1:0] WIN_S = mad_pkg::DEV_W'(mad_pkg::WINDOW_LEN);
    localparam logic [mad_pkg::THRX_W-1:0] WIN_U = mad_pkg::THRX_W'(mad_pkg::WINDOW_LEN);

    state_t                                 state_reg, state_next;
    logic [mad_pkg::THR_W-1:0]              thr_reg, thr_next;
    logic signed [mad_pkg::SAMPLE_W-1:0]    sample_reg, sample_next;
    logic                                   last_reg, last_next;
    logic signed [mad_pkg::SAMPLE_W-1:0]    store_reg [mad_pkg::WINDOW_LEN];
    logic signed [mad_pkg::SAMPLE_W-1:0]    store_next [mad_pkg::WINDOW_LEN];
    logic [mad_pkg::POS_W-1:0]              pos_reg, pos_next;
    logic signed [mad_pkg::WSUM_W-1:0]      wsum_reg, wsum_next;
    logic signed [mad_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic [mad_pkg::CNT_W-1:0]              count_reg, count_next;
    logic [mad_pkg::CNT_W-1:0]              anom_cnt_reg, anom_cnt_next;
    logic [mad_pkg::DEV_W-1:0]              dev_reg, dev_next;
    logic                                   full_reg, full_next;
    logic                                   anom_reg, anom_next;
    logic signed [mad_pkg::SAMPLE_W-1:0]    avg_reg, avg_next;
    logic signed [mad_pkg::SAMPLE_W-1:0]    mean_reg, mean_next;
    logic                                   out_valid_reg, out_valid_next;
    mad_pkg::out_t                          out_data_reg, out_data_next;

    logic                                   in_accept;
    logic                                   out_load;
    logic                                   mean_wanted;
    logic signed [mad_pkg::DEV_W-1:0]       dev_signed;
    logic [mad_pkg::WSUM_W-1:0]             wsum_abs;
    logic [mad_pkg::PROD_W-1:0]             avg_prod;
    logic [mad_pkg::SAMPLE_W-1:0]           avg_mag;
    logic [mad_pkg::QUO_W-1:0]              total_mag;
    logic [mad_pkg::SAMPLE_W-1:0]           quo_low;
    mad_pkg::div_req_t                      div_req;
    mad_pkg::div_rsp_t                      div_rsp;

    mad_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign mean_wanted = last_reg && (count_reg != '0);

    assign dev_signed = mad_pkg::DEV_W'(sample_reg) * WIN_S - mad_pkg::DEV_W'(wsum_reg);
    assign wsum_abs   = unsigned'(wsum_reg[mad_pkg::WSUM_W-1] ? -wsum_reg : wsum_reg);
    assign avg_prod   = mad_pkg::PROD_W'(wsum_abs) * mad_pkg::PROD_W'(mad_pkg::RECIP_MUL);
    assign avg_mag    = avg_prod[mad_pkg::RECIP_SHIFT +: mad_pkg::SAMPLE_W];
    assign total_mag  = mad_pkg::QUO_W'(unsigned'(total_reg[mad_pkg::TOTAL_W-1] ?
                                                   -total_reg : total_reg));
    assign quo_low    = div_rsp.quotient[mad_pkg::SAMPLE_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        thr_next       = thr_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        store_next     = store_reg;
        pos_next       = pos_reg;
        wsum_next      = wsum_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        anom_cnt_next  = anom_cnt_reg;
        dev_next       = dev_reg;
        full_next      = full_reg;
        anom_next      = anom_reg;
        avg_next       = avg_reg;
        mean_next      = mean_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = total_mag;
        div_req.divisor  = count_reg;

        if (cfg_valid && cfg_ready)
        begin
            thr_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = in_data.sample;
                    last_next   = in_data.last;
                    state_next  = S_UPD;
                end
            end
            S_UPD:
            begin
                wsum_next = wsum_reg - mad_pkg::WSUM_W'(store_reg[pos_reg])
                            + mad_pkg::WSUM_W'(sample_reg);
                store_next[pos_reg] = sample_reg;
                pos_next = (pos_reg == mad_pkg::POS_W'(mad_pkg::WINDOW_LEN - 1)) ?
                           '0 : pos_reg + 1'b1;
                if (count_reg < mad_pkg::CNT_W'(mad_pkg::MAX_SAMPLES))
                begin
                    total_next = total_reg + mad_pkg::TOTAL_W'(sample_reg);
                    count_next = count_reg + 1'b1;
                end
                state_next = S_DEV;
            end
            S_DEV:
            begin
                dev_next   = unsigned'(dev_signed[mad_pkg::DEV_W-1] ?
                                       -dev_signed : dev_signed);
                full_next  = (count_reg >= mad_pkg::CNT_W'(mad_pkg::WINDOW_LEN));
                state_next = S_CMP;
            end
            S_CMP:
            begin
                mean_next = '0;
                if (full_reg)
                begin
                    avg_next = wsum_reg[mad_pkg::WSUM_W-1] ? -signed'(avg_mag) : signed'(avg_mag);
                end
                else
                begin
                    avg_next = '0;
                end
                anom_next = full_reg &&
                            (dev_reg > mad_pkg::DEV_W'(WIN_U * mad_pkg::THRX_W'(thr_reg)));
                if (anom_next && (anom_cnt_reg < mad_pkg::CNT_W'(mad_pkg::MAX_SAMPLES)))
                begin
                    anom_cnt_next = anom_cnt_reg + 1'b1;
                end
                if (mean_wanted)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_MEAN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MEAN:
            begin
                if (!div_rsp.busy)
                begin
                    mean_next  = total_reg[mad_pkg::TOTAL_W-1] ?
                                 -signed'(quo_low) : signed'(quo_low);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.moving_avg    = avg_reg;
                    out_data_next.window_full   = full_reg;
                    out_data_next.anomaly       = anom_reg;
                    out_data_next.anomaly_total = anom_cnt_reg;
                    out_data_next.overall_mean  = mean_reg;
                    out_data_next.final_res     = last_reg;
                    if (last_reg)
                    begin
                        for (int i = 0; i < mad_pkg::WINDOW_LEN; i++)
                        begin
                            store_next[i] = '0;
                        end
                        pos_next      = '0;
                        wsum_next     = '0;
                        total_next    = '0;
                        count_next    = '0;
                        anom_cnt_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= mad_pkg::THR_RESET;
            for (int i = 0; i < mad_pkg::WINDOW_LEN; i++)
            begin
                store_reg[i] <= '0;
            end
            pos_reg       <= '0;
            wsum_reg      <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            anom_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            store_reg     <= store_next;
            pos_reg       <= pos_next;
            wsum_reg      <= wsum_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            anom_cnt_reg  <= anom_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        last_reg     <= last_next;
        dev_reg      <= dev_next;
        full_reg     <= full_next;
        anom_reg     <= anom_next;
        avg_reg      <= avg_next;
        mean_reg     <= mean_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MAD_ASSERT_NEXT(a_accept_starts, in_accept, state_reg == S_UPD, "item not started")
    `MAD_ASSERT_IMP(a_anom_le_count, 1'b1, anom_cnt_reg <= count_reg, "anomaly count too high")
    `MAD_ASSERT_IMP(a_div_owner, div_rsp.busy, state_reg == S_MEAN, "divider busy off mean step")
    `MAD_ASSERT_NEXT(a_last_clears, out_load && last_reg, wsum_reg == '0 && count_reg == '0, "not cleared")

endmodule
